// File: hdl/pwd_pkg.sv
// Shared types and constants for the peer wire message deframer.
package pwd_pkg;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_KEEPALIVE = 2'd0,
        KIND_HEADER    = 2'd1,
        KIND_PAYLOAD   = 2'd2,
        KIND_ERROR     = 2'd3
    } t_kind;

    // Error codes
    typedef enum logic [1:0] {
        ERR_NONE    = 2'd0,
        ERR_BAD_ID  = 2'd1,
        ERR_BAD_LEN = 2'd2
    } t_err;

    // Message ids
    localparam logic [3:0] ID_CHOKE          = 4'd0;
    localparam logic [3:0] ID_UNCHOKE        = 4'd1;
    localparam logic [3:0] ID_INTERESTED     = 4'd2;
    localparam logic [3:0] ID_NOT_INTERESTED = 4'd3;
    localparam logic [3:0] ID_HAVE           = 4'd4;
    localparam logic [3:0] ID_BITFIELD       = 4'd5;
    localparam logic [3:0] ID_REQUEST        = 4'd6;
    localparam logic [3:0] ID_PIECE          = 4'd7;
    localparam logic [3:0] ID_CANCEL         = 4'd8;

    // Payload length rules
    localparam logic [31:0] HAVE_LEN      = 32'd4;
    localparam logic [31:0] REQUEST_LEN   = 32'd12;
    localparam logic [31:0] PIECE_MIN_LEN = 32'd8;
    localparam logic [31:0] PIECE_MAX_LEN = 32'd16392;

    // One result item
    typedef struct packed {
        t_kind       kind;
        logic [3:0]  id;
        logic [15:0] plen;
        logic [7:0]  data;
        t_err        err;
        logic        last;
    } t_result;

endpackage

// File: hdl/pwd_in_reg.sv
// Input register stage for received bytes.
module pwd_in_reg
    import pwd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,
    output logic       o_valid,
    output logic [7:0] o_byte,
    input  logic       i_take
);

    logic       r_valid;
    logic [7:0] r_byte;

    // Accept when empty or when the held item moves on this cycle
    assign o_s_tready = !r_valid || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_s_tvalid && o_s_tready) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    // Capture payload
    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_byte <= i_s_tdata;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;

endmodule

// File: hdl/pwd_parse.sv
// Framing state and per-byte decode of the peer wire stream.
module pwd_parse
    import pwd_pkg::*;
#(
    parameter int MAX_PAYLOAD = 32768
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_byte,
    input  logic       i_out_free,
    output logic       o_take,
    output logic       o_res_valid,
    output t_result    o_res
);

    localparam int LEN_W = $clog2(MAX_PAYLOAD + 1);

    typedef enum logic [3:0] {
        PH_PREFIX  = 4'b0001,
        PH_ID      = 4'b0010,
        PH_PAYLOAD = 4'b0100,
        PH_HALT    = 4'b1000
    } t_phase;

    t_phase           r_phase, n_phase;
    logic [1:0]       r_cnt, n_cnt;
    logic [31:0]      r_accum, n_accum;
    logic [3:0]       r_id, n_id;
    logic [LEN_W-1:0] r_left, n_left;
    logic [31:0]      plen;
    logic             left_last;

    // Payload length allowed for a given id
    function automatic logic length_fits(input logic [31:0] len, input logic [3:0] id);
        logic ok;
        case (id) inside
            ID_CHOKE, ID_UNCHOKE, ID_INTERESTED, ID_NOT_INTERESTED: ok = (len == 32'd0);
            ID_HAVE:                ok = (len == HAVE_LEN);
            ID_REQUEST, ID_CANCEL:  ok = (len == REQUEST_LEN);
            ID_PIECE:               ok = (len >= PIECE_MIN_LEN) && (len <= PIECE_MAX_LEN);
            ID_BITFIELD:            ok = 1'b1;
            default:                ok = 1'b0;
        endcase
        return ok;
    endfunction

    assign plen      = r_accum - 32'd1;
    assign left_last = (r_left <= LEN_W'(1));

    // Decode one byte against the current phase
    always_comb begin
        n_phase     = r_phase;
        n_cnt       = r_cnt;
        n_accum     = r_accum;
        n_id        = r_id;
        n_left      = r_left;
        o_res_valid = 1'b0;
        o_res       = '{kind: KIND_KEEPALIVE, id: 4'd0, plen: 16'd0, data: 8'd0,
                        err: ERR_NONE, last: 1'b1};
        unique case (r_phase)
            PH_PREFIX: begin
                n_accum = {r_accum[23:0], i_byte};
                if (r_cnt == 2'd3) begin
                    n_cnt = 2'd0;
                    if (n_accum == 32'd0) begin
                        o_res_valid = 1'b1;
                    end else begin
                        n_phase = PH_ID;
                    end
                end else begin
                    n_cnt = r_cnt + 2'd1;
                end
            end
            PH_ID: begin
                o_res_valid = 1'b1;
                if (i_byte > {4'd0, ID_CANCEL}) begin
                    n_phase   = PH_HALT;
                    o_res.kind = KIND_ERROR;
                    o_res.err  = ERR_BAD_ID;
                end else if (plen > 32'(MAX_PAYLOAD) || !length_fits(plen, i_byte[3:0])) begin
                    n_phase    = PH_HALT;
                    o_res.kind = KIND_ERROR;
                    o_res.err  = ERR_BAD_LEN;
                    o_res.id   = i_byte[3:0];
                end else begin
                    n_id       = i_byte[3:0];
                    n_accum    = 32'd0;
                    o_res.kind = KIND_HEADER;
                    o_res.id   = i_byte[3:0];
                    if (plen == 32'd0) begin
                        n_phase = PH_PREFIX;
                    end else begin
                        n_left     = plen[LEN_W-1:0];
                        n_phase    = PH_PAYLOAD;
                        o_res.plen = plen[15:0];
                        o_res.last = 1'b0;
                    end
                end
            end
            PH_PAYLOAD: begin
                o_res_valid = 1'b1;
                o_res.kind  = KIND_PAYLOAD;
                o_res.id    = r_id;
                o_res.data  = i_byte;
                o_res.last  = left_last;
                if (left_last) begin
                    n_left  = '0;
                    n_phase = PH_PREFIX;
                end else begin
                    n_left = r_left - LEN_W'(1);
                end
            end
            PH_HALT: begin
                // drop every byte until reset
            end
            default: begin
                n_phase = PH_HALT;
            end
        endcase
    end

    // Consume the held byte when its result, if any, has a place to go
    assign o_take = i_valid && (!o_res_valid || i_out_free);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_PREFIX;
            r_cnt   <= 2'd0;
            r_accum <= 32'd0;
            r_id    <= 4'd0;
            r_left  <= '0;
        end else if (o_take) begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_accum <= n_accum;
            r_id    <= n_id;
            r_left  <= n_left;
        end
    end

    // Halt is terminal until reset
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_HALT |=> r_phase == PH_HALT)
        else $error("deframer left halt without reset");

    // No result is produced while halted
    a_halt_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_HALT |-> !o_res_valid)
        else $error("result produced while halted");

    // Final payload byte returns to prefix gathering
    a_payload_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_take && r_phase == PH_PAYLOAD && left_last) |=> r_phase == PH_PREFIX)
        else $error("payload end did not return to prefix phase");

    // Prefix counter only runs in the prefix phase
    a_cnt_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd0 |-> r_phase == PH_PREFIX)
        else $error("prefix count set outside prefix phase");

endmodule

// File: hdl/pwd_out_reg.sv
// Result register driving the output stream.
module pwd_out_reg
    import pwd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_res,
    output logic    o_free,
    output logic    o_m_tvalid,
    input  logic    i_m_tready,
    output t_result o_res
);

    logic    r_valid;
    t_result r_res;

    // Room for a new result when empty or draining this cycle
    assign o_free = !r_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_valid <= 1'b0;
        end
    end

    // Hold result payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_res      = r_res;

endmodule

// File: hdl/peer_wire_message_deframer.sv
// Top level of the peer wire message deframer.
//
//  channel   dir  handshake                        payload
//  s_axis    in   i_s_axis_tvalid/o_s_axis_tready  tdata[7:0] rx_byte
//  m_axis    out  o_m_axis_tvalid/i_m_axis_tready  tdata, tuser msg_kind, tlast last
//
// One byte per cycle while the output is not stalled; an accepted byte passes the
// input register, then is decoded into the result register.
// Reset is synchronous, active low, and clears framing state and both valids;
// a halted block returns to prefix gathering only through reset.
// A stalled output holds its result; the input register still takes a byte
// whenever it is empty, and bytes that produce no result pass without waiting.
module peer_wire_message_deframer
    import pwd_pkg::*;
#(
    parameter int MAX_PAYLOAD = 32768
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] rx_byte
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [3:0] msg_id, [19:4] body_len, [27:20] data_byte, [29:28] error_code,
    // [31:30] zero
    output logic [31:0] o_m_axis_tdata,
    output logic [1:0]  o_m_axis_tuser,   // [1:0] msg_kind
    output logic        o_m_axis_tlast
);

    logic       in_valid;
    logic [7:0] in_byte;
    logic       take;
    logic       out_free;
    logic       res_valid;
    t_result    res;
    t_result    out_res;

    pwd_in_reg u_in_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_axis_tvalid),
        .o_s_tready (o_s_axis_tready),
        .i_s_tdata  (i_s_axis_tdata),
        .o_valid    (in_valid),
        .o_byte     (in_byte),
        .i_take     (take)
    );

    pwd_parse #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (in_valid),
        .i_byte      (in_byte),
        .i_out_free  (out_free),
        .o_take      (take),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    pwd_out_reg u_out_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (take && res_valid),
        .i_res      (res),
        .o_free     (out_free),
        .o_m_tvalid (o_m_axis_tvalid),
        .i_m_tready (i_m_axis_tready),
        .o_res      (out_res)
    );

    // Pack result fields onto the stream
    assign o_m_axis_tdata = {2'b00, out_res.err, out_res.data, out_res.plen, out_res.id};
    assign o_m_axis_tuser = out_res.kind;
    assign o_m_axis_tlast = out_res.last;

endmodule

// File: verif/tb_top.sv
// Testbench for the peer wire message deframer: framed byte streams checked by a predictor.
module tb_top
    import pwd_pkg::*;
();

    localparam int PAYLOAD_CAP  = 32768;
    localparam int RANDOM_BYTES = 720;
    localparam int HOLD_CYCLES  = 200;
    localparam int STALL_LIMIT  = 3000;
    localparam int DRAIN_LIMIT  = 4000;

    // Predictor framing phases
    typedef enum logic [1:0] {
        PH_LENGTH,
        PH_MSGID,
        PH_BODY,
        PH_STOPPED
    } t_phase;

    // Scoreboard: predicts results per received byte and checks them in order
    class deframe_checker;
        t_phase      phase;
        int          prefix_seen;
        logic [31:0] length_acc;
        logic [3:0]  msg_id;
        logic [31:0] body_left;
        t_result     due_results[$];
        int          fail_cnt;
        int          checked_cnt;

        function new();
            phase       = PH_LENGTH;
            prefix_seen = 0;
            length_acc  = '0;
            msg_id      = '0;
            body_left   = '0;
            fail_cnt    = 0;
            checked_cnt = 0;
        endfunction

        // Per-id payload size rules
        function bit length_suits(logic [31:0] plen, logic [3:0] id);
            case (id)
                ID_CHOKE, ID_UNCHOKE, ID_INTERESTED, ID_NOT_INTERESTED: return plen == 0;
                ID_HAVE:               return plen == HAVE_LEN;
                ID_REQUEST, ID_CANCEL: return plen == REQUEST_LEN;
                ID_PIECE:              return plen >= PIECE_MIN_LEN && plen <= PIECE_MAX_LEN;
                ID_BITFIELD:           return 1'b1;
                default:               return 1'b0;
            endcase
        endfunction

        function void take_rx_byte(logic [7:0] b);
            t_result     r;
            logic [31:0] plen;
            r = '0;
            case (phase)
                // Gather the big-endian length prefix
                PH_LENGTH: begin
                    length_acc = {length_acc[23:0], b};
                    prefix_seen++;
                    if (prefix_seen == 4) begin
                        prefix_seen = 0;
                        if (length_acc == 0) begin
                            r.kind = KIND_KEEPALIVE;
                            r.last = 1'b1;
                            due_results.push_back(r);
                        end else begin
                            phase = PH_MSGID;
                        end
                    end
                end
                // Validate the id and the payload size, then emit the header or the error
                PH_MSGID: begin
                    plen = length_acc - 32'd1;
                    r.last = 1'b1;
                    if (b > ID_CANCEL) begin
                        phase  = PH_STOPPED;
                        r.kind = KIND_ERROR;
                        r.err  = ERR_BAD_ID;
                    end else if (plen > 32'(PAYLOAD_CAP) || !length_suits(plen, b[3:0])) begin
                        phase  = PH_STOPPED;
                        r.kind = KIND_ERROR;
                        r.id   = b[3:0];
                        r.err  = ERR_BAD_LEN;
                    end else begin
                        msg_id     = b[3:0];
                        length_acc = '0;
                        r.kind     = KIND_HEADER;
                        r.id       = b[3:0];
                        r.plen     = plen[15:0];
                        r.last     = (plen == 0);
                        body_left  = plen;
                        phase      = (plen == 0) ? PH_LENGTH : PH_BODY;
                    end
                    due_results.push_back(r);
                end
                // Pass payload bytes, mark the final one
                PH_BODY: begin
                    r.kind = KIND_PAYLOAD;
                    r.id   = msg_id;
                    r.data = b;
                    r.last = (body_left <= 1);
                    if (r.last) phase = PH_LENGTH;
                    else body_left--;
                    due_results.push_back(r);
                end
                default: ;
            endcase
        endfunction

        function void check_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                fail_cnt++;
            end
        endfunction

        function void match_result(t_result got);
            t_result want;
            if (due_results.size() == 0) begin
                $error("unexpected result: kind %0d id %0d", got.kind, got.id);
                fail_cnt++;
                return;
            end
            want = due_results.pop_front();
            checked_cnt++;
            check_field("msg_kind", 16'(want.kind), 16'(got.kind));
            check_field("msg_id", 16'(want.id), 16'(got.id));
            check_field("body_len", want.plen, got.plen);
            check_field("data_byte", 16'(want.data), 16'(got.data));
            check_field("error_code", 16'(want.err), 16'(got.err));
            check_field("last", 16'(want.last), 16'(got.last));
        endfunction
    endclass

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        rx_valid  = 1'b0;
    logic        rx_ready;
    logic [7:0]  rx_byte   = 8'd0;
    logic        res_valid;
    logic        res_ready = 1'b0;
    logic [31:0] res_data;
    logic [1:0]  res_kind;
    logic        res_last;

    deframe_checker board;
    int   idle_cycles  = 0;
    int   burst_left   = 0;
    int   bytes_pushed = 0;
    int   frames_sent  = 0;
    logic holdoff_ask  = 1'b0;
    logic [7:0] body[$];

    peer_wire_message_deframer #(
        .MAX_PAYLOAD(PAYLOAD_CAP)
    ) i_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (rx_valid),
        .o_s_axis_tready (rx_ready),
        .i_s_axis_tdata  (rx_byte),
        .o_m_axis_tvalid (res_valid),
        .i_m_axis_tready (res_ready),
        .o_m_axis_tdata  (res_data),
        .o_m_axis_tuser  (res_kind),
        .o_m_axis_tlast  (res_last)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Check results, predict from accepted bytes, watch for a hung handshake
    always @(posedge clk) begin : monitor
        t_result got;
        if (rst_n) begin
            if (res_valid && res_ready) begin
                got.kind = t_kind'(res_kind);
                got.id   = res_data[3:0];
                got.plen = res_data[19:4];
                got.data = res_data[27:20];
                got.err  = t_err'(res_data[29:28]);
                got.last = res_last;
                board.match_result(got);
            end
            if (rx_valid && rx_ready) board.take_rx_byte(rx_byte);
            if ((res_valid && res_ready) || (rx_valid && rx_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $error("no handshake for %0d cycles", STALL_LIMIT);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // Result side backpressure: random modes, plus a long hold-off on request
    int   hold_left    = 0;
    int   mode_left    = 0;
    int   ready_mode   = 0;
    logic holdoff_seen = 1'b0;

    always @(posedge clk) begin
        if (!rst_n) begin
            res_ready <= 1'b0;
        end else if (hold_left != 0) begin
            res_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (holdoff_ask != holdoff_seen) begin
            holdoff_seen <= holdoff_ask;
            hold_left    <= HOLD_CYCLES;
            res_ready    <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                ready_mode <= $urandom_range(0, 3);
                mode_left  <= $urandom_range(32, 256);
            end else begin
                mode_left <= mode_left - 1;
            end
            case (ready_mode)
                0:       res_ready <= 1'b1;
                1:       res_ready <= 1'($urandom_range(0, 1));
                2:       res_ready <= ($urandom_range(0, 3) == 0);
                default: res_ready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    // Offer one byte, idling between bursts, and hold it until accepted
    task automatic push_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap != 0) begin
                rx_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 48);
        end
        rx_valid <= 1'b1;
        rx_byte  <= b;
        do @(posedge clk); while (!rx_ready);
        burst_left--;
        bytes_pushed++;
    endtask

    // Send a length prefix, then the id and the queued body when the prefix is nonzero
    task automatic send_frame(input logic [31:0] prefix, input logic [7:0] id_byte);
        for (int i = 3; i >= 0; i--) push_byte(prefix[8*i +: 8]);
        if (prefix != 0) begin
            push_byte(id_byte);
            foreach (body[i]) push_byte(body[i]);
        end
        body.delete();
        frames_sent++;
    endtask

    task automatic send_msg(input logic [3:0] id, input int plen);
        repeat (plen) body.push_back(8'($urandom));
        send_frame(32'(plen + 1), {4'd0, id});
    endtask

    task automatic pause_until_drained();
        rx_valid <= 1'b0;
        burst_left = 0;
        do @(posedge clk); while (board.due_results.size() != 0);
    endtask

    initial begin : stimulus
        int         pick;
        int         plen;
        int         start;
        int         msg_idx;
        logic [3:0] id;
        string      closing;

        board = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: keep-alive and every id at a legal size
        send_frame(32'd0, 8'd0);
        send_msg(ID_CHOKE, 0);
        send_msg(ID_UNCHOKE, 0);
        send_msg(ID_INTERESTED, 0);
        send_msg(ID_NOT_INTERESTED, 0);
        send_msg(ID_HAVE, HAVE_LEN);
        send_msg(ID_REQUEST, REQUEST_LEN);
        send_msg(ID_CANCEL, REQUEST_LEN);
        send_msg(ID_PIECE, PIECE_MIN_LEN);
        send_msg(ID_BITFIELD, 0);
        body = '{8'h00, 8'hFF, 8'h55, 8'hAA};
        send_frame(32'd5, {4'd0, ID_BITFIELD});
        send_msg(ID_BITFIELD, 1);
        send_frame(32'd0, 8'd0);
        send_frame(32'd0, 8'd0);
        pause_until_drained();

        // Random well-formed traffic, mostly short messages
        start   = bytes_pushed;
        msg_idx = 0;
        while (bytes_pushed - start < RANDOM_BYTES) begin
            if (msg_idx == 10 || msg_idx == 70) holdoff_ask <= ~holdoff_ask;
            if (msg_idx == 40) pause_until_drained();
            if ($urandom_range(0, 19) == 0) begin
                send_frame(32'd0, 8'd0);
            end else begin
                id = 4'($urandom_range(0, 8));
                case (id)
                    ID_HAVE:               plen = HAVE_LEN;
                    ID_REQUEST, ID_CANCEL: plen = REQUEST_LEN;
                    ID_PIECE:    plen = ($urandom_range(0, 15) == 0) ?
                                        $urandom_range(41, 200) : $urandom_range(8, 40);
                    ID_BITFIELD: plen = ($urandom_range(0, 15) == 0) ?
                                        $urandom_range(25, 300) : $urandom_range(0, 24);
                    default:     plen = 0;
                endcase
                send_msg(id, plen);
            end
            msg_idx++;
        end

        // Close with one error, which halts the block, then show trailing bytes are dropped
        pick = $urandom_range(0, 2);
        case (pick)
            0: begin
                closing = "unsupported id";
                send_frame(32'($urandom) | 32'd1, 8'($urandom_range(9, 255)));
            end
            1: begin
                closing = "payload size against id rule";
                id = 4'($urandom_range(0, 8));
                case (id)
                    ID_HAVE:               plen = ($urandom_range(0, 1) != 0) ? 3 : 5;
                    ID_REQUEST, ID_CANCEL: plen = ($urandom_range(0, 1) != 0) ? 11 : 13;
                    ID_PIECE:    plen = ($urandom_range(0, 1) != 0) ?
                                        $urandom_range(0, 7) : PIECE_MAX_LEN + 1;
                    ID_BITFIELD: plen = PAYLOAD_CAP + 1;
                    default:     plen = $urandom_range(1, 20);
                endcase
                send_frame(32'(plen + 1), {4'd0, id});
            end
            default: begin
                closing = "oversized length prefix";
                send_frame(32'hFFFF_FFFF, {4'd0, ID_BITFIELD});
            end
        endcase
        repeat (16) push_byte(8'($urandom));
        rx_valid <= 1'b0;

        // Drain, then wait on for any stray result
        for (int n = 0; n < DRAIN_LIMIT && board.due_results.size() != 0; n++)
            @(posedge clk);
        repeat (16) @(posedge clk);
        if (board.due_results.size() != 0) begin
            $error("%0d expected results never arrived", board.due_results.size());
            board.fail_cnt++;
        end

        $display("Covered %0d frames, %0d bytes in, %0d results checked, bursty input.",
                 frames_sent, bytes_pushed, board.checked_cnt);
        $display("Stream ended on a %s error; trailing bytes were dropped.", closing);
        if (board.fail_cnt == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// File: filelist.f
hdl/pwd_pkg.sv
hdl/pwd_in_reg.sv
hdl/pwd_parse.sv
hdl/pwd_out_reg.sv
hdl/peer_wire_message_deframer.sv
verif/tb_top.sv
